### rtl/probe_receiver_handshake_fsm_defines.svh
// assertion helpers used by prh_ctrl
`ifndef PROBE_RECEIVER_HANDSHAKE_FSM_DEFINES_SVH
`define PROBE_RECEIVER_HANDSHAKE_FSM_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PRH_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PRH_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/prh_pkg.sv
package prh_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_HOP_GAP     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_SEQ   = 2'd2;

    localparam logic [7:0]  RST_HOP_GAP     = 8'd1;
    localparam logic [15:0] RST_MAX_RETRIES = 16'd10;
    localparam logic [31:0] RST_START_SEQ   = 32'd0;

    localparam logic [1:0] MODE_START   = 2'd0;
    localparam logic [1:0] MODE_PACKET  = 2'd1;
    localparam logic [1:0] MODE_TIMEOUT = 2'd2;

    localparam logic [1:0] KIND_REQ  = 2'd0;
    localparam logic [1:0] KIND_CHAL = 2'd1;
    localparam logic [1:0] KIND_HOPS = 2'd2;

    localparam logic [2:0] PH_REQ   = 3'd0;
    localparam logic [2:0] PH_CHAL  = 3'd1;
    localparam logic [2:0] PH_FIND  = 3'd2;
    localparam logic [2:0] PH_FOUND = 3'd3;
    localparam logic [2:0] PH_CHIRP = 3'd4;

    localparam logic [7:0]  LEAST_HOP_INIT = 8'hFF;
    localparam logic [15:0] MISS_MAX       = 16'hFFFF;

    // ceiling divide: 9-bit dividend, one quotient bit per step
    localparam int DIV_N_W   = 9;
    localparam int DIV_CNT_W = 4;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = 4'(DIV_N_W - 1);

    typedef struct packed {
        logic [1:0]  mode;
        logic        crc_ok;
        logic [31:0] pkt_request_number;
        logic [31:0] pkt_challenge;
        logic [31:0] pkt_chirp_number;
        logic [7:0]  pkt_hop_limit;
    } t_prh_item;

    typedef struct packed {
        logic        send_valid;
        logic [1:0]  send_kind;
        logic [31:0] send_sequence;
        logic [31:0] send_request_number;
        logic [31:0] send_challenge;
        logic [7:0]  send_hop_groups;
        logic [2:0]  link_state;
        logic [7:0]  least_hop_limit;
        logic        abort_flag;
    } t_prh_result;

    typedef struct packed {
        logic load;       // apply an item
        logic div_load;   // start the hop group divide
        logic div_step;
        logic finish;     // apply the find-phase timeout with the quotient
    } t_prh_cmd;

    typedef struct packed {
        logic div_item;
        logic div_last;
    } t_prh_sts;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIN
    } t_prh_state;

endpackage

### rtl/prh_in_if.sv
interface prh_in_if import prh_pkg::*;;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic        crc_ok;
    logic [31:0] pkt_request_number;
    logic [31:0] pkt_challenge;
    logic [31:0] pkt_chirp_number;
    logic [7:0]  pkt_hop_limit;

    modport source (
        output valid, mode, crc_ok, pkt_request_number, pkt_challenge,
               pkt_chirp_number, pkt_hop_limit,
        input  ready
    );
    modport sink (
        input  valid, mode, crc_ok, pkt_request_number, pkt_challenge,
               pkt_chirp_number, pkt_hop_limit,
        output ready
    );
endinterface

### rtl/prh_out_if.sv
interface prh_out_if import prh_pkg::*;;
    logic        valid;
    logic        ready;
    logic        send_valid;
    logic [1:0]  send_kind;
    logic [31:0] send_sequence;
    logic [31:0] send_request_number;
    logic [31:0] send_challenge;
    logic [7:0]  send_hop_groups;
    logic [2:0]  link_state;
    logic [7:0]  least_hop_limit;
    logic        abort_flag;

    modport source (
        output valid, send_valid, send_kind, send_sequence, send_request_number,
               send_challenge, send_hop_groups, link_state, least_hop_limit,
               abort_flag,
        input  ready
    );
    modport sink (
        input  valid, send_valid, send_kind, send_sequence, send_request_number,
               send_challenge, send_hop_groups, link_state, least_hop_limit,
               abort_flag,
        output ready
    );
endinterface

### rtl/prh_divider.sv
module prh_divider import prh_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  logic               i_step,
    input  logic [DIV_N_W-1:0] i_dividend,
    input  logic [7:0]         i_divisor,
    output logic [7:0]         o_quotient,
    output logic               o_last
);

    logic [7:0]           r_rem, n_rem;
    logic [DIV_N_W-1:0]   r_quo, n_quo;
    logic [7:0]           r_dsr;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [8:0]           trial;
    logic [8:0]           diff;

    // restoring divide, remainder always below the divisor so it fits 8 bits
    always_comb begin
        trial = {r_rem, r_quo[DIV_N_W-1]};
        diff  = trial - {1'b0, r_dsr};
        n_rem = r_rem;
        n_quo = r_quo;
        n_cnt = r_cnt;
        if (i_load) begin
            n_rem = '0;
            n_quo = i_dividend;
            n_cnt = DIV_LAST_STEP;
        end else if (i_step) begin
            if (trial >= {1'b0, r_dsr}) begin
                n_rem = diff[7:0];
                n_quo = {r_quo[DIV_N_W-2:0], 1'b1};
            end else begin
                n_rem = trial[7:0];
                n_quo = {r_quo[DIV_N_W-2:0], 1'b0};
            end
            if (r_cnt != '0) begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        if (i_load) begin
            r_dsr <= i_divisor;
        end
    end

    assign o_quotient = r_quo[7:0];
    assign o_last     = (r_cnt == '0);

endmodule

### rtl/prh_datapath.sv
module prh_datapath import prh_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_prh_item             i_item,
    input  t_prh_cmd              i_cmd,
    output t_prh_sts              o_sts,
    output t_prh_result           o_result
);

    logic [7:0]  r_hop_gap;
    logic [15:0] r_max_retries;
    logic [31:0] r_start_seq;

    logic [2:0]  r_phase, n_phase;
    logic [31:0] r_req, n_req;
    logic [31:0] r_seq, n_seq;
    logic [31:0] r_chal, n_chal;
    logic [7:0]  r_least, n_least;
    logic [7:0]  r_hops, n_hops;
    logic [15:0] r_miss, n_miss;
    logic        r_aborted, n_aborted;
    t_prh_result r_result, n_result;

    logic [7:0]         gap;
    logic [DIV_N_W-1:0] dividend;
    logic [7:0]         quotient;
    logic               div_last;
    logic [15:0]        miss_inc;
    logic               miss_over;
    logic               snd;
    logic [1:0]         snd_kind;
    logic [31:0]        seq_base;
    logic [2:0]         pkt_phase;

    assign gap      = (r_hop_gap == '0) ? 8'd1 : r_hop_gap;
    assign dividend = {1'b0, r_least} + {1'b0, gap} - 9'd1;

    prh_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (i_cmd.div_load),
        .i_step     (i_cmd.div_step),
        .i_dividend (dividend),
        .i_divisor  (gap),
        .o_quotient (quotient),
        .o_last     (div_last)
    );

    assign miss_inc  = (r_miss != MISS_MAX) ? r_miss + 16'd1 : r_miss;
    assign miss_over = (miss_inc > r_max_retries);

    assign o_sts.div_item = !r_aborted && (i_item.mode == MODE_TIMEOUT) && (r_phase == PH_FIND);
    assign o_sts.div_last = div_last;

    always_comb begin
        n_phase   = r_phase;
        n_req     = r_req;
        n_seq     = r_seq;
        n_chal    = r_chal;
        n_least   = r_least;
        n_hops    = r_hops;
        n_miss    = r_miss;
        n_aborted = r_aborted;
        snd       = 1'b0;
        snd_kind  = KIND_REQ;
        seq_base  = r_seq;
        pkt_phase = PH_FIND;

        if (i_cmd.load && !r_aborted) begin
            unique case (i_item.mode)
                MODE_START: begin
                    n_req    = '0;
                    seq_base = r_start_seq;
                    n_phase  = PH_REQ;
                    snd      = 1'b1;
                    snd_kind = KIND_REQ;
                end
                MODE_PACKET: begin
                    if (i_item.crc_ok && i_item.pkt_request_number == r_req) begin
                        if (r_phase == PH_REQ) begin
                            n_chal   = i_item.pkt_challenge;
                            n_req    = r_req + 32'd1;
                            snd      = 1'b1;
                            snd_kind = KIND_CHAL;
                            n_miss   = '0;
                            n_phase  = PH_CHAL;
                        end else if (r_phase <= PH_FOUND
                                     && i_item.pkt_challenge == r_chal) begin
                            pkt_phase = (r_phase == PH_FOUND) ? PH_FOUND : PH_FIND;
                            n_miss    = '0;
                            if (i_item.pkt_chirp_number != '0) begin
                                n_phase = PH_CHIRP;
                            end else begin
                                n_phase = pkt_phase;
                                if (pkt_phase == PH_FIND && i_item.pkt_hop_limit < r_least) begin
                                    n_least = i_item.pkt_hop_limit;
                                end
                            end
                        end
                    end
                end
                MODE_TIMEOUT: begin
                    // find-phase timeouts go through the divider instead
                    unique case (r_phase)
                        PH_REQ: begin
                            snd      = 1'b1;
                            snd_kind = KIND_REQ;
                        end
                        PH_CHAL: begin
                            snd      = 1'b1;
                            snd_kind = KIND_CHAL;
                        end
                        PH_FOUND: begin
                            snd      = 1'b1;
                            snd_kind = KIND_HOPS;
                        end
                        default: begin
                            snd = 1'b0;
                        end
                    endcase
                    n_miss = miss_inc;
                    if (miss_over) begin
                        n_aborted = 1'b1;
                    end
                end
                default: begin
                    snd = 1'b0;
                end
            endcase
        end else if (i_cmd.finish) begin
            n_hops   = quotient;
            n_phase  = PH_FOUND;
            n_req    = r_req + 32'd1;
            snd      = 1'b1;
            snd_kind = KIND_HOPS;
            n_miss   = miss_inc;
            if (miss_over) begin
                n_aborted = 1'b1;
            end
        end

        if (snd) begin
            n_seq = seq_base + 32'd1;
        end

        n_result                     = '0;
        n_result.send_valid          = snd;
        n_result.send_kind           = snd ? snd_kind : KIND_REQ;
        n_result.send_sequence       = snd ? n_seq : '0;
        n_result.send_request_number = snd ? n_req : '0;
        n_result.send_challenge      = (snd && snd_kind != KIND_REQ) ? n_chal : '0;
        n_result.send_hop_groups     = (snd && snd_kind == KIND_HOPS) ? n_hops : '0;
        n_result.link_state          = n_phase;
        n_result.least_hop_limit     = n_least;
        n_result.abort_flag          = n_aborted;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hop_gap     <= RST_HOP_GAP;
            r_max_retries <= RST_MAX_RETRIES;
            r_start_seq   <= RST_START_SEQ;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_HOP_GAP:     r_hop_gap     <= i_cfg_data[7:0];
                CFG_MAX_RETRIES: r_max_retries <= i_cfg_data[15:0];
                CFG_START_SEQ:   r_start_seq   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_REQ;
            r_req     <= '0;
            r_seq     <= RST_START_SEQ;
            r_chal    <= '0;
            r_least   <= LEAST_HOP_INIT;
            r_hops    <= '0;
            r_miss    <= '0;
            r_aborted <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_req     <= n_req;
            r_seq     <= n_seq;
            r_chal    <= n_chal;
            r_least   <= n_least;
            r_hops    <= n_hops;
            r_miss    <= n_miss;
            r_aborted <= n_aborted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load || i_cmd.finish) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

endmodule

### rtl/prh_ctrl.sv
`include "probe_receiver_handshake_fsm_defines.svh"

module prh_ctrl import prh_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_prh_sts i_sts,
    output t_prh_cmd o_cmd
);

    t_prh_state r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       accept;

    // a new item only while idle and once the result register is free or being emptied
    assign o_in_ready = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && i_sts.div_item) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (i_sts.div_last) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.load     = accept && !i_sts.div_item;
                o_cmd.div_load = accept && i_sts.div_item;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            ST_FIN: begin
                o_cmd.finish = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_comb begin
        priority if (o_cmd.load || o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `PRH_ASSERT_NXT(a_div_entry, i_clk, i_rst_n, o_cmd.div_load, r_state == ST_DIV, "divide did not start after a find-phase timeout")
    `PRH_ASSERT_NXT(a_fin_result, i_clk, i_rst_n, r_state == ST_FIN, r_out_valid, "no result after the divide finished")
    `PRH_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, r_out_valid && !i_out_ready, !o_cmd.load && !o_cmd.finish, "result overwritten before transfer")

endmodule

### rtl/probe_receiver_handshake_fsm.sv
// Receiver side of the pre-probe connection handshake. Items (start, packet arrived,
// timeout) come in on i_in and each yields exactly one result on o_out; configuration
// is written through i_cfg_we/i_cfg_idx/i_cfg_data; the user must do so only while the
// block is idle, as the block does not check it. Start, packet and most timeout results
// are registered at transfer. A find-hop-limit timeout runs the hop group ceiling
// divide, a restoring divider giving one quotient bit per cycle. The result sits in an
// output register; an item is taken while idle once that register is free or draining.
module probe_receiver_handshake_fsm import prh_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    prh_in_if.sink                i_in,
    prh_out_if.source             o_out
);

    t_prh_item   item;
    t_prh_result result;
    t_prh_cmd    cmd;
    t_prh_sts    sts;

    assign item.mode               = i_in.mode;
    assign item.crc_ok             = i_in.crc_ok;
    assign item.pkt_request_number = i_in.pkt_request_number;
    assign item.pkt_challenge      = i_in.pkt_challenge;
    assign item.pkt_chirp_number   = i_in.pkt_chirp_number;
    assign item.pkt_hop_limit      = i_in.pkt_hop_limit;

    prh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    prh_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (item),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_result   (result)
    );

    assign o_out.send_valid          = result.send_valid;
    assign o_out.send_kind           = result.send_kind;
    assign o_out.send_sequence       = result.send_sequence;
    assign o_out.send_request_number = result.send_request_number;
    assign o_out.send_challenge      = result.send_challenge;
    assign o_out.send_hop_groups     = result.send_hop_groups;
    assign o_out.link_state          = result.link_state;
    assign o_out.least_hop_limit     = result.least_hop_limit;
    assign o_out.abort_flag          = result.abort_flag;

endmodule
